FILE: hw/rtl/i2cm_pkg.sv
package i2cm_pkg;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_START = 4'd1,
    PH_WBIT  = 4'd2,
    PH_WACK  = 4'd3,
    PH_RBIT  = 4'd4,
    PH_MACK  = 4'd5,
    PH_STOP  = 4'd6
  } phase_t;

  typedef enum logic [1:0] {
    HS_FIRST  = 2'd0,
    HS_SECOND = 2'd1,
    HS_THIRD  = 2'd2
  } half_t;

  localparam logic [2:0] BIT_MSB = 3'd7;

  typedef struct packed {
    logic       func;
    logic [6:0] dev_addr;
    logic       read_not_write;
    logic [7:0] byte_count;
    logic [7:0] tx_byte;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       tx_taken;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       success;
  } result_t;

endpackage

FILE: hw/rtl/i2cm_core.sv
module i2cm_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  i2cm_pkg::item_t  item,
  output i2cm_pkg::result_t res
);

  i2cm_pkg::phase_t phase_r, phase_nxt;
  i2cm_pkg::half_t  half_r, half_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] left_r, left_nxt;
  logic       read_r, read_nxt;
  logic [6:0] addr_r, addr_nxt;
  logic       failed_r, failed_nxt;
  logic       hold_scl_r, hold_sda_r;
  logic       scl, sda;
  logic [7:0] rx_shift;

  assign rx_shift = {shift_r[6:0], item.sda_in};

  always_comb begin
    phase_nxt  = phase_r;
    half_nxt   = half_r;
    bit_nxt    = bit_r;
    shift_nxt  = shift_r;
    left_nxt   = left_r;
    read_nxt   = read_r;
    addr_nxt   = addr_r;
    failed_nxt = failed_r;
    scl        = hold_scl_r;
    sda        = hold_sda_r;
    res        = '0;

    if (item.func) begin
      // a command while busy is ignored and the drive is held
      if (phase_r == i2cm_pkg::PH_IDLE) begin
        addr_nxt   = item.dev_addr;
        read_nxt   = item.read_not_write;
        left_nxt   = item.byte_count;
        failed_nxt = 1'b0;
        half_nxt   = i2cm_pkg::HS_FIRST;
        bit_nxt    = 3'd0;
        shift_nxt  = 8'd0;
        phase_nxt  = i2cm_pkg::PH_START;
        scl        = 1'b0;
        sda        = 1'b0;
      end
    end else begin
      case (phase_r)
        i2cm_pkg::PH_START: begin
          if (half_r == i2cm_pkg::HS_FIRST) begin
            scl      = 1'b0;
            sda      = 1'b1;
            half_nxt = i2cm_pkg::HS_SECOND;
          end else begin
            scl       = 1'b1;
            sda       = 1'b1;
            half_nxt  = i2cm_pkg::HS_FIRST;
            shift_nxt = {addr_r, read_r};
            bit_nxt   = i2cm_pkg::BIT_MSB;
            phase_nxt = i2cm_pkg::PH_WBIT;
          end
        end
        i2cm_pkg::PH_WBIT: begin
          sda = ~shift_r[bit_r];
          if (half_r == i2cm_pkg::HS_FIRST) begin
            scl      = 1'b1;
            half_nxt = i2cm_pkg::HS_SECOND;
          end else begin
            scl      = 1'b0;
            half_nxt = i2cm_pkg::HS_FIRST;
            if (bit_r == 3'd0) begin
              phase_nxt = i2cm_pkg::PH_WACK;
            end else begin
              bit_nxt = bit_r - 3'd1;
            end
          end
        end
        i2cm_pkg::PH_WACK: begin
          sda = 1'b0;
          if (half_r == i2cm_pkg::HS_FIRST) begin
            scl      = 1'b1;
            half_nxt = i2cm_pkg::HS_SECOND;
          end else begin
            scl      = 1'b0;
            half_nxt = i2cm_pkg::HS_FIRST;
            if (item.sda_in) begin
              // nack aborts into stop
              failed_nxt = 1'b1;
              phase_nxt  = i2cm_pkg::PH_STOP;
            end else if (left_r == 8'd0) begin
              phase_nxt = i2cm_pkg::PH_STOP;
            end else if (read_r) begin
              shift_nxt = 8'd0;
              bit_nxt   = i2cm_pkg::BIT_MSB;
              phase_nxt = i2cm_pkg::PH_RBIT;
            end else begin
              shift_nxt    = item.tx_byte;
              res.tx_taken = 1'b1;
              left_nxt     = left_r - 8'd1;
              bit_nxt      = i2cm_pkg::BIT_MSB;
              phase_nxt    = i2cm_pkg::PH_WBIT;
            end
          end
        end
        i2cm_pkg::PH_RBIT: begin
          sda = 1'b0;
          if (half_r == i2cm_pkg::HS_FIRST) begin
            scl      = 1'b1;
            half_nxt = i2cm_pkg::HS_SECOND;
          end else begin
            scl       = 1'b0;
            half_nxt  = i2cm_pkg::HS_FIRST;
            shift_nxt = rx_shift;
            if (bit_r == 3'd0) begin
              res.rx_valid = 1'b1;
              res.rx_byte  = rx_shift;
              left_nxt     = left_r - 8'd1;
              phase_nxt    = i2cm_pkg::PH_MACK;
            end else begin
              bit_nxt = bit_r - 3'd1;
            end
          end
        end
        i2cm_pkg::PH_MACK: begin
          // ack every byte but the last
          sda = (left_r != 8'd0);
          if (half_r == i2cm_pkg::HS_FIRST) begin
            scl      = 1'b1;
            half_nxt = i2cm_pkg::HS_SECOND;
          end else begin
            scl      = 1'b0;
            half_nxt = i2cm_pkg::HS_FIRST;
            if (left_r != 8'd0) begin
              shift_nxt = 8'd0;
              bit_nxt   = i2cm_pkg::BIT_MSB;
              phase_nxt = i2cm_pkg::PH_RBIT;
            end else begin
              phase_nxt = i2cm_pkg::PH_STOP;
            end
          end
        end
        i2cm_pkg::PH_STOP: begin
          if (half_r == i2cm_pkg::HS_FIRST) begin
            scl      = 1'b1;
            sda      = 1'b1;
            half_nxt = i2cm_pkg::HS_SECOND;
          end else if (half_r == i2cm_pkg::HS_SECOND) begin
            scl      = 1'b0;
            sda      = 1'b1;
            half_nxt = i2cm_pkg::HS_THIRD;
          end else begin
            scl          = 1'b0;
            sda          = 1'b0;
            half_nxt     = i2cm_pkg::HS_FIRST;
            res.done_res = 1'b1;
            res.success  = ~failed_r;
            phase_nxt    = i2cm_pkg::PH_IDLE;
          end
        end
        default: begin
          // idle and unused codes release both lines
          phase_nxt = i2cm_pkg::PH_IDLE;
          half_nxt  = i2cm_pkg::HS_FIRST;
          scl       = 1'b0;
          sda       = 1'b0;
        end
      endcase
    end

    res.scl_drive_low = scl;
    res.sda_drive_low = sda;
    res.busy_res      = (phase_nxt != i2cm_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= i2cm_pkg::PH_IDLE;
      half_r     <= i2cm_pkg::HS_FIRST;
      bit_r      <= 3'd0;
      shift_r    <= 8'd0;
      left_r     <= 8'd0;
      read_r     <= 1'b0;
      addr_r     <= 7'd0;
      failed_r   <= 1'b0;
      hold_scl_r <= 1'b0;
      hold_sda_r <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      half_r     <= half_nxt;
      bit_r      <= bit_nxt;
      shift_r    <= shift_nxt;
      left_r     <= left_nxt;
      read_r     <= read_nxt;
      addr_r     <= addr_nxt;
      failed_r   <= failed_nxt;
      hold_scl_r <= scl;
      hold_sda_r <= sda;
    end
  end

endmodule

FILE: hw/rtl/i2c_master_sequencer.sv
// I2C master sequencer with open-drain drive. Each input transfer is a command
// (func=1, taken only while idle) or a half-period tick carrying the sampled SDA
// level; every input transfer yields exactly one result transfer with the line
// drive and status for that item. The sequencer state advances once per item,
// so one item is taken every clock unless input stalls; its result goes to the
// output register, or to the skid entry when the output stalls. An output
// register plus a skid entry keep input flowing for one more item while a
// result waits; input stalls only when both hold unclaimed results.
module i2c_master_sequencer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_func,
  input  logic [6:0] in_dev_addr,
  input  logic       in_read_not_write,
  input  logic [7:0] in_byte_count,
  input  logic [7:0] in_tx_byte,
  input  logic       in_sda_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_scl_drive_low,
  output logic       out_sda_drive_low,
  output logic       out_busy_res,
  output logic       out_tx_taken,
  output logic       out_rx_valid,
  output logic [7:0] out_rx_byte,
  output logic       out_done_res,
  output logic       out_success
);

  i2cm_pkg::item_t   item;
  i2cm_pkg::result_t res;
  i2cm_pkg::result_t out_r, skid_r;
  logic              out_valid_r, skid_valid_r;
  logic              accept, out_free;

  assign item = '{func: in_func, dev_addr: in_dev_addr,
                  read_not_write: in_read_not_write, byte_count: in_byte_count,
                  tx_byte: in_tx_byte, sda_in: in_sda_in};

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;

  i2cm_core u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .step (accept),
    .item (item),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_free) begin
        skid_valid_r <= 1'b0;
      end
    end else if (accept) begin
      if (out_free) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_free) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_free) begin
        out_r <= skid_r;
      end
    end else if (accept) begin
      if (out_free) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_scl_drive_low = out_r.scl_drive_low;
  assign out_sda_drive_low = out_r.sda_drive_low;
  assign out_busy_res      = out_r.busy_res;
  assign out_tx_taken      = out_r.tx_taken;
  assign out_rx_valid      = out_r.rx_valid;
  assign out_rx_byte       = out_r.rx_byte;
  assign out_done_res      = out_r.done_res;
  assign out_success       = out_r.success;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a result while the output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid entry filled while the output register was free");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_stall |=> out_valid_r && !skid_valid_r)
    else $error("skid entry not moved to the output register");

  a_rx_tx_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.tx_taken && out_r.rx_valid) &&
                    !(out_r.done_res && out_r.busy_res))
    else $error("conflicting status flags in one result");
`endif

endmodule
